/* rtl/sfcs_pkg.sv */
// Shared types and constants of the SPI NOR flash command sequencer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sfcs_pkg;

   localparam int unsigned SECTOR_BYTES = 4096;
   localparam int unsigned PAGE_BYTES   = 256;
   localparam int unsigned SECTOR_SHIFT = $clog2(SECTOR_BYTES);

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] MODE_ID     = 3'd0;
   localparam logic [2:0] MODE_STATUS = 3'd1;
   localparam logic [2:0] MODE_WREN   = 3'd2;
   localparam logic [2:0] MODE_ERASE  = 3'd3;
   localparam logic [2:0] MODE_PBEGIN = 3'd4;
   localparam logic [2:0] MODE_PDATA  = 3'd5;
   localparam logic [2:0] MODE_RBEGIN = 3'd6;
   localparam logic [2:0] MODE_RDATA  = 3'd7;

   localparam logic [7:0] CMD_READ_ID     = 8'h90;
   localparam logic [7:0] CMD_READ_STATUS = 8'h05;
   localparam logic [7:0] CMD_WRITE_EN    = 8'h06;
   localparam logic [7:0] CMD_ERASE       = 8'h20;
   localparam logic [7:0] CMD_PROGRAM     = 8'h02;
   localparam logic [7:0] CMD_READ        = 8'h03;
   localparam logic [7:0] BYTE_DUMMY      = 8'h00;

   typedef enum logic [3:0] {
      JOB_ERROR,
      JOB_PDATA,
      JOB_RDATA,
      JOB_ID,
      JOB_STATUS,
      JOB_WREN,
      JOB_ERASE,
      JOB_PROG,
      JOB_READ
   } job_op_type;

   typedef struct packed {
      job_op_type  op;
      logic [23:0] addr;
      logic [7:0]  data;
      logic        close;
   } job_type;

endpackage

`default_nettype wire

/* rtl/spi_nor_flash_command_sequencer.sv */
// Top level of the SPI NOR flash command sequencer: front end, job queue and
// byte sequencer. Depends on sfcs_pkg, sfcs_front, sfcs_queue and sfcs_back.
//
//   Channel  Direction  Handshake               Payload
//   req      in         req_valid / req_ready   mode, address, length, data_byte
//   rsp      out        rsp_valid / rsp_ready   mosi_byte, frame_end, capture,
//                                               run_last, error
//
// The front end takes one item per cycle while the four-entry job queue has room.
// The back end sends one result byte per cycle while results are taken: data
// and error items give one byte, commands one to six bytes, set by its byte counter.
// A synchronous reset empties the queue and closes any open transfer.
// A stalled result holds its register; the queue absorbs items meanwhile.
`default_nettype none

module spi_nor_flash_command_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_mode,
   input  wire logic [23:0] req_address,
   input  wire logic [15:0] req_length,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_mosi_byte,
   output logic             rsp_frame_end,
   output logic             rsp_capture,
   output logic             rsp_run_last,
   output logic             rsp_error
);
   import sfcs_pkg::*;

   job_type push_job, head_job;
   logic    push_valid, queue_full, queue_empty, pop;

   sfcs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_address   (req_address),
      .req_length    (req_length),
      .req_data_byte (req_data_byte),
      .queue_full    (queue_full),
      .push_valid    (push_valid),
      .push_job      (push_job)
   );

   sfcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head_job   (head_job)
   );

   sfcs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .empty         (queue_empty),
      .head_job      (head_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_mosi_byte (rsp_mosi_byte),
      .rsp_frame_end (rsp_frame_end),
      .rsp_capture   (rsp_capture),
      .rsp_run_last  (rsp_run_last),
      .rsp_error     (rsp_error)
   );

endmodule

`default_nettype wire

/* rtl/sfcs_front.sv */
// Front end: accepts request items, tracks the open transfer and turns each
// item into one job for the queue. Depends on sfcs_pkg.
`default_nettype none

module sfcs_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [2:0]       req_mode,
   input  wire logic [23:0]      req_address,
   input  wire logic [15:0]      req_length,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             queue_full,
   output logic                  push_valid,
   output sfcs_pkg::job_type     push_job
);
   import sfcs_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PROG,
      PH_READ
   } phase_type;

   phase_type   phase_ff, phase_in, want_phase;
   logic [15:0] left_ff, left_in, left_dec, prog_len;
   logic        accept;

   assign req_ready  = !queue_full;
   assign accept     = req_valid && !queue_full;
   assign push_valid = accept;

   always_comb begin
      phase_in       = phase_ff;
      left_in        = left_ff;
      left_dec       = left_ff - 16'd1;
      prog_len       = (req_length > 16'(PAGE_BYTES)) ? 16'(PAGE_BYTES) : req_length;
      want_phase     = (req_mode == MODE_PDATA) ? PH_PROG : PH_READ;
      push_job.op    = JOB_ERROR;
      push_job.addr  = req_address;
      push_job.data  = req_data_byte;
      push_job.close = 1'b0;
      if (req_mode inside {MODE_PDATA, MODE_RDATA}) begin
         if (phase_ff == want_phase && left_ff != 16'd0) begin
            push_job.op    = (req_mode == MODE_PDATA) ? JOB_PDATA : JOB_RDATA;
            push_job.close = (left_dec == 16'd0);
            left_in        = left_dec;
            if (left_dec == 16'd0) begin
               phase_in = PH_IDLE;
            end
         end
      end else if (phase_ff == PH_IDLE) begin
         case (req_mode)
            MODE_ID: begin
               push_job.op = JOB_ID;
            end
            MODE_STATUS: begin
               push_job.op = JOB_STATUS;
            end
            MODE_WREN: begin
               push_job.op = JOB_WREN;
            end
            MODE_ERASE: begin
               push_job.op   = JOB_ERASE;
               push_job.addr = req_address << SECTOR_SHIFT;
            end
            MODE_PBEGIN: begin
               push_job.op    = JOB_PROG;
               push_job.close = (prog_len == 16'd0);
               if (prog_len != 16'd0) begin
                  phase_in = PH_PROG;
                  left_in  = prog_len;
               end
            end
            MODE_RBEGIN: begin
               push_job.op    = JOB_READ;
               push_job.close = (req_length == 16'd0);
               if (req_length != 16'd0) begin
                  phase_in = PH_READ;
                  left_in  = req_length;
               end
            end
            default: begin
               push_job.op = JOB_ERROR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         left_ff  <= 16'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/sfcs_queue.sv */
// Short job queue between the front end and the byte sequencer.
// Depends on sfcs_pkg for the job type and the queue depth.
`default_nettype none

module sfcs_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire sfcs_pkg::job_type push_job,
   output logic                   full,
   input  wire logic              pop,
   output logic                   empty,
   output sfcs_pkg::job_type      head_job
);
   import sfcs_pkg::*;

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;
   logic              do_push, do_pop;

   assign full     = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push_valid && !full;
   assign do_pop   = pop && !empty;
   assign head_job = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/sfcs_back.sv */
// Back end: walks the head job byte by byte into the result register.
// Depends on sfcs_pkg for the job type and the flash command bytes.
`default_nettype none

module sfcs_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              empty,
   input  wire sfcs_pkg::job_type head_job,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_mosi_byte,
   output logic                   rsp_frame_end,
   output logic                   rsp_capture,
   output logic                   rsp_run_last,
   output logic                   rsp_error
);
   import sfcs_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       fe_ff, fe_in, cap_ff, cap_in, last_ff, last_in, err_ff, err_in;
   logic       load, fire;

   assign load = !valid_ff || rsp_ready;
   assign fire = load && !empty;
   assign pop  = fire && last_in;

   always_comb begin
      byte_in = BYTE_DUMMY;
      fe_in   = 1'b0;
      cap_in  = 1'b0;
      last_in = 1'b0;
      err_in  = 1'b0;
      case (head_job.op)
         JOB_PDATA: begin
            byte_in = head_job.data;
            fe_in   = head_job.close;
            last_in = 1'b1;
         end
         JOB_RDATA: begin
            fe_in   = head_job.close;
            cap_in  = 1'b1;
            last_in = 1'b1;
         end
         JOB_ID: begin
            if (idx_ff == 3'd0) begin
               byte_in = CMD_READ_ID;
            end
            cap_in  = (idx_ff >= 3'd4);
            fe_in   = (idx_ff == 3'd5);
            last_in = (idx_ff == 3'd5);
         end
         JOB_STATUS: begin
            if (idx_ff == 3'd0) begin
               byte_in = CMD_READ_STATUS;
            end else begin
               fe_in   = 1'b1;
               cap_in  = 1'b1;
               last_in = 1'b1;
            end
         end
         JOB_WREN: begin
            byte_in = CMD_WRITE_EN;
            fe_in   = 1'b1;
            last_in = 1'b1;
         end
         JOB_ERASE, JOB_PROG: begin
            case (idx_ff)
               3'd0: begin
                  byte_in = CMD_WRITE_EN;
                  fe_in   = 1'b1;
               end
               3'd1: byte_in = (head_job.op == JOB_ERASE) ? CMD_ERASE : CMD_PROGRAM;
               3'd2: byte_in = head_job.addr[23:16];
               3'd3: byte_in = head_job.addr[15:8];
               default: begin
                  byte_in = head_job.addr[7:0];
                  fe_in   = (head_job.op == JOB_ERASE) || head_job.close;
                  last_in = 1'b1;
               end
            endcase
         end
         JOB_READ: begin
            case (idx_ff)
               3'd0: byte_in = CMD_READ;
               3'd1: byte_in = head_job.addr[23:16];
               3'd2: byte_in = head_job.addr[15:8];
               default: begin
                  byte_in = head_job.addr[7:0];
                  fe_in   = head_job.close;
                  last_in = 1'b1;
               end
            endcase
         end
         default: begin
            err_in  = 1'b1;
            last_in = 1'b1;
         end
      endcase
   end

   always_comb begin
      valid_in = load ? !empty : valid_ff;
      idx_in   = idx_ff;
      if (fire) begin
         idx_in = last_in ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff <= byte_in;
         fe_ff   <= fe_in;
         cap_ff  <= cap_in;
         last_ff <= last_in;
         err_ff  <= err_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_mosi_byte = byte_ff;
   assign rsp_frame_end = fe_ff;
   assign rsp_capture   = cap_ff;
   assign rsp_run_last  = last_ff;
   assign rsp_error     = err_ff;

endmodule

`default_nettype wire

/* verif/tb_spi_nor_flash_command_sequencer.sv */
// Self-checking testbench for the SPI NOR flash command sequencer: directed and
// random request items against a built-in predictor of the MOSI byte stream.
// Depends on sfcs_pkg and spi_nor_flash_command_sequencer.
`timescale 1ns / 100ps

module tb_spi_nor_flash_command_sequencer;
   import sfcs_pkg::*;

   typedef enum {XFER_IDLE, XFER_PROG, XFER_READ} xfer_state_type;

   typedef struct {
      logic [7:0] mosi_byte;
      logic       frame_end;
      logic       capture;
      logic       run_last;
      logic       error;
   } flash_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_mode = MODE_ID;
   logic [23:0] req_address = '0;
   logic [15:0] req_length = '0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_mosi_byte;
   logic        rsp_frame_end;
   logic        rsp_capture;
   logic        rsp_run_last;
   logic        rsp_error;

   flash_byte_type expected_bytes[$];
   xfer_state_type xfer_phase = XFER_IDLE;
   logic [15:0]    bytes_due = '0;
   int             failures = 0;
   int             send_idle_pct = 7;
   int             recv_stall_pct = 78;

   spi_nor_flash_command_sequencer dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_address   (req_address),
      .req_length    (req_length),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_mosi_byte (rsp_mosi_byte),
      .rsp_frame_end (rsp_frame_end),
      .rsp_capture   (rsp_capture),
      .rsp_run_last  (rsp_run_last),
      .rsp_error     (rsp_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic void push_byte(input logic [7:0] b, input logic fe, input logic cap);
      flash_byte_type e;
      e.mosi_byte = b;
      e.frame_end = fe;
      e.capture   = cap;
      e.run_last  = 1'b0;
      e.error     = 1'b0;
      expected_bytes.push_back(e);
   endfunction

   function automatic void push_address(input logic [23:0] a, input logic fe_last);
      push_byte(a[23:16], 1'b0, 1'b0);
      push_byte(a[15:8], 1'b0, 1'b0);
      push_byte(a[7:0], fe_last, 1'b0);
   endfunction

   function automatic void predict_frame(input logic [2:0] mode, input logic [23:0] addr,
                                         input logic [15:0] len, input logic [7:0] data);
      xfer_state_type want;
      logic [23:0]    sector_addr;
      logic [15:0]    page_len;
      flash_byte_type last;
      if (mode == MODE_PDATA || mode == MODE_RDATA) begin
         want = (mode == MODE_PDATA) ? XFER_PROG : XFER_READ;
         if (xfer_phase != want || bytes_due == 0) begin
            last = '{BYTE_DUMMY, 1'b0, 1'b0, 1'b1, 1'b1};
            expected_bytes.push_back(last);
            return;
         end
         bytes_due = bytes_due - 16'd1;
         if (bytes_due == 0) xfer_phase = XFER_IDLE;
         if (mode == MODE_PDATA) push_byte(data, bytes_due == 0, 1'b0);
         else push_byte(BYTE_DUMMY, bytes_due == 0, 1'b1);
      end else if (xfer_phase != XFER_IDLE) begin
         last = '{BYTE_DUMMY, 1'b0, 1'b0, 1'b1, 1'b1};
         expected_bytes.push_back(last);
         return;
      end else begin
         case (mode)
            MODE_ID: begin
               push_byte(CMD_READ_ID, 1'b0, 1'b0);
               push_address(24'h000000, 1'b0);
               push_byte(BYTE_DUMMY, 1'b0, 1'b1);
               push_byte(BYTE_DUMMY, 1'b1, 1'b1);
            end
            MODE_STATUS: begin
               push_byte(CMD_READ_STATUS, 1'b0, 1'b0);
               push_byte(BYTE_DUMMY, 1'b1, 1'b1);
            end
            MODE_WREN: begin
               push_byte(CMD_WRITE_EN, 1'b1, 1'b0);
            end
            MODE_ERASE: begin
               sector_addr = addr << SECTOR_SHIFT;
               push_byte(CMD_WRITE_EN, 1'b1, 1'b0);
               push_byte(CMD_ERASE, 1'b0, 1'b0);
               push_address(sector_addr, 1'b1);
            end
            MODE_PBEGIN: begin
               page_len = (len > PAGE_BYTES) ? 16'(PAGE_BYTES) : len;
               push_byte(CMD_WRITE_EN, 1'b1, 1'b0);
               push_byte(CMD_PROGRAM, 1'b0, 1'b0);
               push_address(addr, page_len == 0);
               if (page_len != 0) begin
                  xfer_phase = XFER_PROG;
                  bytes_due  = page_len;
               end
            end
            default: begin
               push_byte(CMD_READ, 1'b0, 1'b0);
               push_address(addr, len == 0);
               if (len != 0) begin
                  xfer_phase = XFER_READ;
                  bytes_due  = len;
               end
            end
         endcase
      end
      last = expected_bytes.pop_back();
      last.run_last = 1'b1;
      expected_bytes.push_back(last);
   endfunction

   task automatic send_request(input logic [2:0] mode, input logic [23:0] addr,
                               input logic [15:0] len, input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_address   <= addr;
      req_length    <= len;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      predict_frame(mode, addr, len, data);
      @(negedge clock);
   endtask

   task automatic send_data_item(input logic [2:0] mode);
      send_request(mode, 24'($urandom), 16'($urandom), 8'($urandom));
   endtask

   task automatic check_field(input string name, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, act_val);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      flash_byte_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected result item, mosi_byte %0h", rsp_mosi_byte);
            failures++;
         end else begin
            e = expected_bytes.pop_front();
            check_field("mosi_byte", e.mosi_byte, rsp_mosi_byte);
            check_field("frame_end", e.frame_end, rsp_frame_end);
            check_field("capture", e.capture, rsp_capture);
            check_field("run_last", e.run_last, rsp_run_last);
            check_field("error", e.error, rsp_error);
         end
      end
   end

   task automatic test_fixed_commands();
      send_request(MODE_ID, 24'hFFFFFF, 16'hFFFF, 8'hFF);
      send_request(MODE_STATUS, 24'h000000, 16'h0000, 8'h00);
      send_request(MODE_WREN, 24'h5A5A5A, 16'h1234, 8'h77);
      send_request(MODE_ERASE, 24'h000000, 16'h0000, 8'h00);
      send_request(MODE_ERASE, 24'hFFFFFF, 16'h0000, 8'h00);
      send_request(MODE_ERASE, 24'h000FFF, 16'h0000, 8'h00);
      send_request(MODE_ERASE, 24'h800001, 16'h0000, 8'h00);
   endtask

   task automatic test_program_frames();
      send_request(MODE_PBEGIN, 24'hFFFFFF, 16'h0000, 8'h00);
      send_request(MODE_PBEGIN, 24'hA5C3F0, 16'h0002, 8'h00);
      send_request(MODE_PDATA, 24'h000000, 16'h0000, 8'h00);
      send_request(MODE_PDATA, 24'h000000, 16'h0000, 8'hFF);
   endtask

   task automatic test_read_frames();
      send_request(MODE_RBEGIN, 24'h000000, 16'h0000, 8'h00);
      send_request(MODE_RBEGIN, 24'hFFFFFF, 16'h0002, 8'h00);
      send_data_item(MODE_RDATA);
      send_data_item(MODE_RDATA);
   endtask

   task automatic test_refused_items();
      send_data_item(MODE_PDATA);
      send_data_item(MODE_RDATA);
      send_request(MODE_PBEGIN, 24'h123456, 16'h0001, 8'h00);
      send_request(MODE_ID, 24'h000000, 16'h0000, 8'h00);
      send_request(MODE_RBEGIN, 24'h000010, 16'h0004, 8'h00);
      send_request(MODE_ERASE, 24'h000001, 16'h0000, 8'h00);
      send_data_item(MODE_RDATA);
      send_request(MODE_PDATA, 24'h000000, 16'h0000, 8'h3C);
   endtask

   task automatic test_page_clamp();
      send_request(MODE_PBEGIN, 24'($urandom), 16'hFFFF, 8'h00);
      while (xfer_phase != XFER_IDLE) send_data_item(MODE_PDATA);
   endtask

   task automatic test_random_traffic(input int count);
      logic [2:0]  mode;
      logic [15:0] len;
      int          roll;
      for (int i = 0; i < count; i++) begin
         if (xfer_phase != XFER_IDLE && $urandom_range(99) < 85) begin
            send_data_item((xfer_phase == XFER_PROG) ? MODE_PDATA : MODE_RDATA);
         end else if ($urandom_range(99) < 10) begin
            send_request(3'($urandom_range(7)), 24'($urandom), 16'($urandom_range(0, 40)),
                         8'($urandom));
         end else begin
            case ($urandom_range(5))
               0: mode = MODE_ID;
               1: mode = MODE_STATUS;
               2: mode = MODE_WREN;
               3: mode = MODE_ERASE;
               4: mode = MODE_PBEGIN;
               default: mode = MODE_RBEGIN;
            endcase
            roll = $urandom_range(99);
            if (roll < 8) len = 16'h0000;
            else if (roll < 92) len = 16'($urandom_range(1, 12));
            else len = 16'($urandom_range(13, 40));
            send_request(mode, 24'($urandom), len, 8'($urandom));
         end
      end
      while (xfer_phase != XFER_IDLE)
         send_data_item((xfer_phase == XFER_PROG) ? MODE_PDATA : MODE_RDATA);
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_fixed_commands();
      test_program_frames();
      test_read_frames();
      test_refused_items();
      test_page_clamp();
      test_random_traffic(20);
      send_idle_pct  = 78;
      recv_stall_pct = 7;
      test_random_traffic(20);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_traffic(20);
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0 && expected_bytes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
